### rtl/stl_pkg.sv
// Shared types and constants for the script token lexer.
// Token kind and error codes, keyword table, token and bundle records.
// No dependencies.
package stl_pkg;

    localparam int PREFIX_CHARS_DEF = 6;
    localparam int QUEUE_DEPTH_DEF  = 4;
    localparam int TOKENS_MAX       = 3;

    // token kinds
    localparam logic [5:0] K_LEFT_PAREN    = 6'd0;
    localparam logic [5:0] K_RIGHT_PAREN   = 6'd1;
    localparam logic [5:0] K_LEFT_BRACE    = 6'd2;
    localparam logic [5:0] K_RIGHT_BRACE   = 6'd3;
    localparam logic [5:0] K_COMMA         = 6'd4;
    localparam logic [5:0] K_DOT           = 6'd5;
    localparam logic [5:0] K_MINUS         = 6'd6;
    localparam logic [5:0] K_PLUS          = 6'd7;
    localparam logic [5:0] K_SEMICOLON     = 6'd8;
    localparam logic [5:0] K_SLASH         = 6'd9;
    localparam logic [5:0] K_STAR          = 6'd10;
    localparam logic [5:0] K_BANG          = 6'd11;
    localparam logic [5:0] K_EQUAL         = 6'd13;
    localparam logic [5:0] K_GREATER       = 6'd15;
    localparam logic [5:0] K_LESS          = 6'd17;
    localparam logic [5:0] K_IDENTIFIER    = 6'd19;
    localparam logic [5:0] K_STRING        = 6'd20;
    localparam logic [5:0] K_NUMBER        = 6'd21;
    localparam logic [5:0] K_FIRST_KEYWORD = 6'd22;
    localparam logic [5:0] K_ERROR         = 6'd38;
    localparam logic [5:0] K_END_OF_FILE   = 6'd39;

    // error codes
    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_UNTERM     = 2'd1;
    localparam logic [1:0] ERR_UNEXPECTED = 2'd2;

    // reserved words, first character in the lowest byte, zero padded
    localparam int KEYWORDS = 16;
    localparam logic [63:0] KW_TABLE [KEYWORDS] = '{
        64'h0000_0000_0064_6e61, // and
        64'h0000_0073_7361_6c63, // class
        64'h0000_0000_6573_6c65, // else
        64'h0000_0065_736c_6166, // false
        64'h0000_0000_0072_6f66, // for
        64'h0000_0000_006e_7566, // fun
        64'h0000_0000_0000_6669, // if
        64'h0000_0000_006c_696e, // nil
        64'h0000_0000_0000_726f, // or
        64'h0000_0074_6e69_7270, // print
        64'h0000_6e72_7574_6572, // return
        64'h0000_0072_6570_7573, // super
        64'h0000_0000_7369_6874, // this
        64'h0000_0000_6575_7274, // true
        64'h0000_0000_0072_6176, // var
        64'h0000_0065_6c69_6877  // while
    };

    typedef struct packed {
        logic [5:0]  kind;
        logic [1:0]  err;
        logic [31:0] start;
        logic [15:0] len;
    } token_t;

    // all tokens caused by one input beat
    typedef struct packed {
        logic [1:0]                   count;
        logic [15:0]                  line;
        token_t [TOKENS_MAX-1:0]      tok;
    } bundle_t;

endpackage

### rtl/script_token_lexer.sv
// Top level of the script token lexer: scanner, bundle queue, issue stage.
// Depends on stl_pkg, stl_front, stl_queue, stl_back.
//
//  channel  dir  tdata                     tuser               tlast
//  s_       in   [7:0] text_byte           -                   end_of_text
//  m_       out  [31:0] token_start,       [5:0] token_kind,   last_of_run
//                [47:32] token_length,     [7:6] error_kind
//                [63:48] line_number
//
// One source beat is accepted per cycle while the bundle queue has room.
// Each beat yields zero to three tokens; the issue stage sends one token per
// cycle while m_tready is high, so the output rate is set by the token count, one beat each.
// A token passes through the bundle queue and the issue stage bundle register before it shows on m_.
// aresetn is synchronous and active low; it clears lexer state and queue.
// m_tready low fills the queue and then drops s_tready.
module script_token_lexer
    import stl_pkg::*;
#(
    parameter int PREFIX_CHARS = PREFIX_CHARS_DEF,
    parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,  // [7:0] text_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,  // [31:0] token_start, [47:32] token_length, [63:48] line_number
    output logic [7:0]  m_tuser,  // [5:0] token_kind, [7:6] error_kind
    output logic        m_tlast
);

    logic    push, q_full, pop, head_valid;
    bundle_t push_bundle, head_bundle;

    stl_front #(
        .PREFIX_CHARS(PREFIX_CHARS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_byte    (s_tdata),
        .in_end     (s_tlast),
        .q_full     (q_full),
        .push       (push),
        .push_bundle(push_bundle)
    );

    stl_queue #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_bundle(push_bundle),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_bundle(head_bundle)
    );

    stl_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_bundle(head_bundle),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_user   (m_tuser),
        .out_data   (m_tdata),
        .out_last   (m_tlast)
    );

endmodule

### rtl/stl_front.sv
// Scanner front end: accepts source beats, tracks lexer state, and builds
// the bundle of tokens that each beat completes. Depends on stl_pkg.
module stl_front
    import stl_pkg::*;
#(
    parameter int PREFIX_CHARS = PREFIX_CHARS_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       in_end,
    input  logic       q_full,
    output logic       push,
    output bundle_t    push_bundle
);

    localparam int PW = 8 * PREFIX_CHARS;

    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_LF      = 8'h0a;
    localparam logic [7:0] CH_CR      = 8'h0d;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_BANG    = 8'h21;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_STAR    = 8'h2a;
    localparam logic [7:0] CH_PLUS    = 8'h2b;
    localparam logic [7:0] CH_COMMA   = 8'h2c;
    localparam logic [7:0] CH_MINUS   = 8'h2d;
    localparam logic [7:0] CH_DOT     = 8'h2e;
    localparam logic [7:0] CH_SLASH   = 8'h2f;
    localparam logic [7:0] CH_SEMI    = 8'h3b;
    localparam logic [7:0] CH_LESS    = 8'h3c;
    localparam logic [7:0] CH_EQUAL   = 8'h3d;
    localparam logic [7:0] CH_GREATER = 8'h3e;
    localparam logic [7:0] CH_LBRACE  = 8'h7b;
    localparam logic [7:0] CH_RBRACE  = 8'h7d;

    typedef enum logic [3:0] {
        M_IDLE    = 4'd0,
        M_INT     = 4'd1,
        M_DOT     = 4'd2,
        M_FRAC    = 4'd3,
        M_IDENT   = 4'd4,
        M_STRING  = 4'd5,
        M_OP      = 4'd6,
        M_SLASH   = 4'd7,
        M_COMMENT = 4'd8
    } mode_t;

    function automatic logic is_digit(input logic [7:0] ch);
        return ch >= 8'h30 && ch <= 8'h39;
    endfunction

    function automatic logic is_alpha(input logic [7:0] ch);
        return (ch >= 8'h61 && ch <= 8'h7a) || (ch >= 8'h41 && ch <= 8'h5a) || ch == 8'h5f;
    endfunction

    function automatic logic [5:0] op_kind(input logic [7:0] ch);
        logic [5:0] k;
        case (ch)
            CH_EQUAL:   k = K_EQUAL;
            CH_GREATER: k = K_GREATER;
            CH_LESS:    k = K_LESS;
            default:    k = K_BANG;
        endcase
        return k;
    endfunction

    function automatic logic [5:0] word_kind(input logic [PW-1:0] pre, input logic [15:0] cnt);
        logic [5:0] k;
        k = K_IDENTIFIER;
        for (int w = KEYWORDS - 1; w >= 0; w--) begin
            if (pre == KW_TABLE[w][PW-1:0]) k = K_FIRST_KEYWORD + 6'(w);
        end
        if (cnt > 16'(PREFIX_CHARS)) k = K_IDENTIFIER;
        return k;
    endfunction

    function automatic logic [15:0] sat_inc16(input logic [15:0] v);
        return (v == 16'hffff) ? v : v + 16'd1;
    endfunction

    mode_t         mode_reg, mode_next;
    logic [31:0]   begin_reg, begin_next;
    logic [15:0]   count_reg, count_next;
    logic [31:0]   offset_reg, offset_next;
    logic [15:0]   line_reg, line_next;
    logic [PW-1:0] prefix_reg, prefix_next;
    logic [7:0]    pend_reg, pend_next;

    logic [7:0]  c;
    logic [31:0] pos;
    logic        accept;

    // start of a new token from the idle mode
    mode_t         id_mode;
    logic [15:0]   id_count;
    logic [PW-1:0] id_prefix;
    logic          id_emit;
    logic          id_line;
    logic          id_pend;
    token_t        id_tok;

    // tokens held in the current mode
    logic [1:0] fl_n;
    token_t     fl0, fl1;

    logic                    restart;
    logic [1:0]              n;
    token_t [TOKENS_MAX-1:0] tok;

    assign c        = in_byte;
    assign pos      = offset_reg;
    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    always_comb begin
        id_mode   = M_IDLE;
        id_count  = 16'd1;
        id_prefix = '0;
        id_emit   = 1'b0;
        id_line   = 1'b0;
        id_pend   = 1'b0;
        id_tok    = '{K_ERROR, ERR_NONE, pos, 16'd1};
        if (is_digit(c)) begin
            id_mode = M_INT;
        end else if (is_alpha(c)) begin
            id_mode   = M_IDENT;
            id_prefix = PW'(c);
        end else begin
            unique case (c) inside
                CH_SPACE, CH_CR, CH_TAB: id_count = 16'd0;
                CH_LF: begin
                    id_count = 16'd0;
                    id_line  = 1'b1;
                end
                CH_LPAREN: begin id_emit = 1'b1; id_tok.kind = K_LEFT_PAREN;  end
                CH_RPAREN: begin id_emit = 1'b1; id_tok.kind = K_RIGHT_PAREN; end
                CH_LBRACE: begin id_emit = 1'b1; id_tok.kind = K_LEFT_BRACE;  end
                CH_RBRACE: begin id_emit = 1'b1; id_tok.kind = K_RIGHT_BRACE; end
                CH_COMMA:  begin id_emit = 1'b1; id_tok.kind = K_COMMA;       end
                CH_DOT:    begin id_emit = 1'b1; id_tok.kind = K_DOT;         end
                CH_MINUS:  begin id_emit = 1'b1; id_tok.kind = K_MINUS;       end
                CH_PLUS:   begin id_emit = 1'b1; id_tok.kind = K_PLUS;        end
                CH_SEMI:   begin id_emit = 1'b1; id_tok.kind = K_SEMICOLON;   end
                CH_STAR:   begin id_emit = 1'b1; id_tok.kind = K_STAR;        end
                CH_SLASH:  id_mode = M_SLASH;
                CH_BANG, CH_EQUAL, CH_LESS, CH_GREATER: begin
                    id_mode = M_OP;
                    id_pend = 1'b1;
                end
                CH_QUOTE:  id_mode = M_STRING;
                default: begin
                    id_emit    = 1'b1;
                    id_tok.err = ERR_UNEXPECTED;
                end
            endcase
        end
    end

    always_comb begin
        fl_n = 2'd0;
        fl0  = '0;
        fl1  = '0;
        unique case (mode_reg)
            M_INT, M_FRAC: begin
                fl_n = 2'd1;
                fl0  = '{K_NUMBER, ERR_NONE, begin_reg, count_reg};
            end
            M_DOT: begin
                fl_n = 2'd2;
                fl0  = '{K_NUMBER, ERR_NONE, begin_reg, count_reg};
                fl1  = '{K_DOT, ERR_NONE, pos - 32'd1, 16'd1};
            end
            M_IDENT: begin
                fl_n = 2'd1;
                fl0  = '{word_kind(prefix_reg, count_reg), ERR_NONE, begin_reg, count_reg};
            end
            M_OP: begin
                fl_n = 2'd1;
                fl0  = '{op_kind(pend_reg), ERR_NONE, begin_reg, 16'd1};
            end
            M_SLASH: begin
                fl_n = 2'd1;
                fl0  = '{K_SLASH, ERR_NONE, begin_reg, 16'd1};
            end
            M_STRING: begin
                fl_n = 2'd1;
                fl0  = '{K_ERROR, ERR_UNTERM, begin_reg, count_reg};
            end
            default: ;
        endcase
    end

    always_comb begin
        mode_next   = mode_reg;
        begin_next  = begin_reg;
        count_next  = count_reg;
        offset_next = offset_reg;
        line_next   = line_reg;
        prefix_next = prefix_reg;
        pend_next   = pend_reg;
        restart     = 1'b0;
        n           = 2'd0;
        tok         = '0;
        tok[0]      = fl0;
        tok[1]      = fl1;

        if (in_end) begin
            case (fl_n)
                2'd0:    tok[0] = '{K_END_OF_FILE, ERR_NONE, pos, 16'd0};
                2'd1:    tok[1] = '{K_END_OF_FILE, ERR_NONE, pos, 16'd0};
                default: tok[2] = '{K_END_OF_FILE, ERR_NONE, pos, 16'd0};
            endcase
            n           = fl_n + 2'd1;
            mode_next   = M_IDLE;
            count_next  = 16'd0;
            prefix_next = '0;
        end else begin
            if (offset_reg != 32'hffff_ffff) offset_next = offset_reg + 32'd1;
            unique case (mode_reg)
                M_INT: begin
                    if (is_digit(c)) count_next = sat_inc16(count_reg);
                    else if (c == CH_DOT) mode_next = M_DOT;
                    else restart = 1'b1;
                end
                M_DOT: begin
                    if (is_digit(c)) begin
                        count_next = (count_reg >= 16'hfffe) ? 16'hffff : count_reg + 16'd2;
                        mode_next  = M_FRAC;
                    end else begin
                        restart = 1'b1;
                    end
                end
                M_FRAC: begin
                    if (is_digit(c)) count_next = sat_inc16(count_reg);
                    else restart = 1'b1;
                end
                M_IDENT: begin
                    if (is_alpha(c) || is_digit(c)) begin
                        for (int i = 0; i < PREFIX_CHARS; i++) begin
                            if (count_reg == 16'(i)) prefix_next[8*i +: 8] = c;
                        end
                        count_next = sat_inc16(count_reg);
                    end else begin
                        restart = 1'b1;
                    end
                end
                M_STRING: begin
                    count_next = sat_inc16(count_reg);
                    if (c == CH_LF) line_next = sat_inc16(line_reg);
                    if (c == CH_QUOTE) begin
                        n         = 2'd1;
                        tok[0]    = '{K_STRING, ERR_NONE, begin_reg, sat_inc16(count_reg)};
                        mode_next = M_IDLE;
                    end
                end
                M_OP: begin
                    if (c == CH_EQUAL) begin
                        n         = 2'd1;
                        tok[0]    = '{op_kind(pend_reg) + 6'd1, ERR_NONE, begin_reg, 16'd2};
                        mode_next = M_IDLE;
                    end else begin
                        restart = 1'b1;
                    end
                end
                M_SLASH: begin
                    if (c == CH_SLASH) mode_next = M_COMMENT;
                    else restart = 1'b1;
                end
                M_COMMENT: begin
                    // nothing held, so a restart emits only what the newline does
                    if (c == CH_LF) restart = 1'b1;
                end
                default: restart = 1'b1;
            endcase

            if (restart) begin
                mode_next   = id_mode;
                begin_next  = pos;
                count_next  = id_count;
                prefix_next = id_prefix;
                if (id_line) line_next = sat_inc16(line_reg);
                if (id_pend) pend_next = c;
                if (id_emit) begin
                    case (fl_n)
                        2'd0:    tok[0] = id_tok;
                        2'd1:    tok[1] = id_tok;
                        default: tok[2] = id_tok;
                    endcase
                end
                n = fl_n + {1'b0, id_emit};
            end
        end
    end

    assign push              = accept && (n != 2'd0);
    assign push_bundle.count = n;
    assign push_bundle.line  = line_reg;
    assign push_bundle.tok   = tok;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= M_IDLE;
            begin_reg  <= '0;
            count_reg  <= '0;
            offset_reg <= '0;
            line_reg   <= 16'd1;
            prefix_reg <= '0;
            pend_reg   <= '0;
        end else if (accept) begin
            mode_reg   <= mode_next;
            begin_reg  <= begin_next;
            count_reg  <= count_next;
            offset_reg <= offset_next;
            line_reg   <= line_next;
            prefix_reg <= prefix_next;
            pend_reg   <= pend_next;
        end
    end

endmodule

### rtl/stl_queue.sv
// Bundle queue between scanner and token issue stage.
// Small register FIFO of token bundles. Depends on stl_pkg.
module stl_queue
    import stl_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  bundle_t push_bundle,
    output logic    full,
    input  logic    pop,
    output logic    head_valid,
    output bundle_t head_bundle
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    bundle_t       store [QUEUE_DEPTH];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] fill_reg;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    assign full        = fill_reg == CW'(QUEUE_DEPTH);
    assign head_valid  = fill_reg != '0;
    assign head_bundle = store[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) store[wr_ptr_reg] <= push_bundle;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (push) wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (pop)  rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            case ({push, pop})
                2'b10:   fill_reg <= fill_reg + CW'(1);
                2'b01:   fill_reg <= fill_reg - CW'(1);
                default: ;
            endcase
        end
    end

endmodule

### rtl/stl_back.sv
// Token issue stage: holds one bundle and sends its tokens one beat each.
// Depends on stl_pkg.
module stl_back
    import stl_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        head_valid,
    input  bundle_t     head_bundle,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_user,
    output logic [63:0] out_data,
    output logic        out_last
);

    bundle_t    bundle_reg;
    logic [1:0] idx_reg;
    logic       busy_reg;
    token_t     cur;
    logic       last;

    assign cur       = bundle_reg.tok[idx_reg];
    assign last      = idx_reg == (bundle_reg.count - 2'd1);
    assign pop       = head_valid && (!busy_reg || (out_ready && last));
    assign out_valid = busy_reg;
    assign out_last  = last;
    assign out_user  = {cur.err, cur.kind};
    assign out_data  = {bundle_reg.line, cur.len, cur.start};

    always_ff @(posedge aclk) begin
        if (pop) bundle_reg <= head_bundle;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end else if (pop) begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end else if (busy_reg && out_ready) begin
            if (last) busy_reg <= 1'b0;
            else idx_reg <= idx_reg + 2'd1;
        end
    end

endmodule

### tb/script_token_lexer_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for script_token_lexer: streams source bytes in,
// predicts every token in step with the input and checks the m_ channel.
// Depends on stl_pkg and the script_token_lexer RTL.
module script_token_lexer_tb;
    import stl_pkg::*;

    localparam int PREFIX_BITS   = PREFIX_CHARS_DEF * 8;
    localparam int RANDOM_ITEMS  = 200;
    localparam int STEADY_LEXEMES = 10;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;

    typedef enum logic [3:0] {
        SCAN_IDLE, SCAN_INT, SCAN_DOT, SCAN_FRAC, SCAN_WORD,
        SCAN_STRING, SCAN_OP, SCAN_SLASH, SCAN_COMMENT
    } scan_mode_t;

    typedef struct {
        logic [5:0]  kind;
        logic [1:0]  err;
        logic [31:0] start;
        logic [15:0] len;
        logic [15:0] line;
        logic        last;
    } token_rec_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic [7:0]  m_tuser;
    logic        m_tlast;

    always #10 aclk = ~aclk;

    script_token_lexer dut (.*);

    // scanner state as predicted
    scan_mode_t  scan_mode   = SCAN_IDLE;
    logic [31:0] tok_begin   = '0;
    logic [15:0] tok_count   = '0;
    logic [31:0] src_offset  = '0;
    logic [15:0] src_line    = 16'd1;
    logic [63:0] word_bytes  = '0;
    logic [7:0]  held_op     = '0;

    token_rec_t expected_tokens[$];
    token_rec_t beat_tokens[$];

    int err_count  = 0;
    int items_sent = 0;
    bit idle_on    = 1'b1;
    int rx_hold    = 0;
    int rx_gap     = 0;

    // ---------------------------------------------------------------- predictor

    function automatic bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_alpha(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic void emit_token(logic [5:0] kind, logic [1:0] err,
                                       logic [31:0] start, logic [15:0] len);
        token_rec_t rec;
        rec.kind  = kind;
        rec.err   = err;
        rec.start = start;
        rec.len   = len;
        rec.line  = src_line;
        rec.last  = 1'b0;
        beat_tokens.push_back(rec);
    endfunction

    function automatic void count_up();
        if (tok_count != 16'hFFFF) tok_count++;
    endfunction

    function automatic void line_up();
        if (src_line != 16'hFFFF) src_line++;
    endfunction

    function automatic logic [5:0] word_token_kind();
        if (tok_count > PREFIX_CHARS_DEF) return K_IDENTIFIER;
        for (int w = 0; w < KEYWORDS; w++)
            if (word_bytes[PREFIX_BITS-1:0] == KW_TABLE[w][PREFIX_BITS-1:0])
                return K_FIRST_KEYWORD + 6'(w);
        return K_IDENTIFIER;
    endfunction

    // one-character form; the two-character form is the next kind up
    function automatic logic [5:0] op_base(logic [7:0] c);
        case (c)
            "=": return K_EQUAL;
            ">": return K_GREATER;
            "<": return K_LESS;
            default: return K_BANG;
        endcase
    endfunction

    function automatic void start_token(logic [7:0] c, logic [31:0] pos);
        scan_mode  = SCAN_IDLE;
        tok_begin  = pos;
        tok_count  = 16'd1;
        word_bytes = '0;
        if (is_digit(c)) begin
            scan_mode = SCAN_INT;
        end else if (is_alpha(c)) begin
            scan_mode  = SCAN_WORD;
            word_bytes = {56'd0, c};
        end else begin
            case (c)
                CH_SPACE, CH_CR, CH_TAB: tok_count = '0;
                CH_LF: begin
                    tok_count = '0;
                    line_up();
                end
                "(": emit_token(K_LEFT_PAREN, ERR_NONE, pos, 16'd1);
                ")": emit_token(K_RIGHT_PAREN, ERR_NONE, pos, 16'd1);
                "{": emit_token(K_LEFT_BRACE, ERR_NONE, pos, 16'd1);
                "}": emit_token(K_RIGHT_BRACE, ERR_NONE, pos, 16'd1);
                ",": emit_token(K_COMMA, ERR_NONE, pos, 16'd1);
                ".": emit_token(K_DOT, ERR_NONE, pos, 16'd1);
                "-": emit_token(K_MINUS, ERR_NONE, pos, 16'd1);
                "+": emit_token(K_PLUS, ERR_NONE, pos, 16'd1);
                ";": emit_token(K_SEMICOLON, ERR_NONE, pos, 16'd1);
                "*": emit_token(K_STAR, ERR_NONE, pos, 16'd1);
                "/": scan_mode = SCAN_SLASH;
                "!", "=", "<", ">": begin
                    scan_mode = SCAN_OP;
                    held_op   = c;
                end
                CH_QUOTE: scan_mode = SCAN_STRING;
                default: emit_token(K_ERROR, ERR_UNEXPECTED, pos, 16'd1);
            endcase
        end
    endfunction

    function automatic void flush_pending(logic [31:0] pos);
        case (scan_mode)
            SCAN_INT, SCAN_FRAC: emit_token(K_NUMBER, ERR_NONE, tok_begin, tok_count);
            SCAN_DOT: begin
                emit_token(K_NUMBER, ERR_NONE, tok_begin, tok_count);
                emit_token(K_DOT, ERR_NONE, pos - 32'd1, 16'd1);
            end
            SCAN_WORD:   emit_token(word_token_kind(), ERR_NONE, tok_begin, tok_count);
            SCAN_OP:     emit_token(op_base(held_op), ERR_NONE, tok_begin, 16'd1);
            SCAN_SLASH:  emit_token(K_SLASH, ERR_NONE, tok_begin, 16'd1);
            SCAN_STRING: emit_token(K_ERROR, ERR_UNTERM, tok_begin, tok_count);
            default: ;
        endcase
        scan_mode = SCAN_IDLE;
    endfunction

    function automatic void predict_tokens(logic [7:0] c, logic eot);
        logic [31:0] pos;
        token_rec_t  rec;
        pos = src_offset;
        beat_tokens.delete();
        if (eot) begin
            flush_pending(pos);
            emit_token(K_END_OF_FILE, ERR_NONE, pos, 16'd0);
            tok_count  = '0;
            word_bytes = '0;
        end else begin
            case (scan_mode)
                SCAN_INT:
                    if (is_digit(c)) count_up();
                    else if (c == ".") scan_mode = SCAN_DOT;
                    else begin
                        flush_pending(pos);
                        start_token(c, pos);
                    end
                SCAN_DOT:
                    if (is_digit(c)) begin
                        count_up();
                        count_up();
                        scan_mode = SCAN_FRAC;
                    end else begin
                        flush_pending(pos);
                        start_token(c, pos);
                    end
                SCAN_FRAC:
                    if (is_digit(c)) count_up();
                    else begin
                        flush_pending(pos);
                        start_token(c, pos);
                    end
                SCAN_WORD:
                    if (is_alpha(c) || is_digit(c)) begin
                        if (tok_count < PREFIX_CHARS_DEF) word_bytes[8*tok_count +: 8] = c;
                        count_up();
                    end else begin
                        flush_pending(pos);
                        start_token(c, pos);
                    end
                SCAN_STRING: begin
                    count_up();
                    if (c == CH_LF) line_up();
                    if (c == CH_QUOTE) begin
                        emit_token(K_STRING, ERR_NONE, tok_begin, tok_count);
                        scan_mode = SCAN_IDLE;
                    end
                end
                SCAN_OP:
                    if (c == "=") begin
                        emit_token(op_base(held_op) + 6'd1, ERR_NONE, tok_begin, 16'd2);
                        scan_mode = SCAN_IDLE;
                    end else begin
                        flush_pending(pos);
                        start_token(c, pos);
                    end
                SCAN_SLASH:
                    if (c == "/") scan_mode = SCAN_COMMENT;
                    else begin
                        flush_pending(pos);
                        start_token(c, pos);
                    end
                SCAN_COMMENT:
                    if (c == CH_LF) start_token(c, pos);
                default: start_token(c, pos);
            endcase
            if (src_offset != 32'hFFFF_FFFF) src_offset++;
        end
        foreach (beat_tokens[i]) begin
            rec      = beat_tokens[i];
            rec.last = (i == beat_tokens.size() - 1);
            expected_tokens.push_back(rec);
        end
    endfunction

    // ---------------------------------------------------------------- checker

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            err_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    function automatic void check_token();
        token_rec_t want;
        if (expected_tokens.size() == 0) begin
            err_count++;
            $display("%0t: token with none expected, expected nothing, actual kind %0d start %0d",
                     $time, m_tuser[5:0], m_tdata[31:0]);
        end else begin
            want = expected_tokens.pop_front();
            check_field("token_kind", want.kind, m_tuser[5:0]);
            check_field("error_kind", want.err, m_tuser[7:6]);
            check_field("token_start", want.start, m_tdata[31:0]);
            check_field("token_length", want.len, m_tdata[47:32]);
            check_field("line_number", want.line, m_tdata[63:48]);
            check_field("last_of_run", want.last, m_tlast);
        end
    endfunction

    // result side: check each beat, then pick m_tready for the next cycle
    always @(posedge aclk) begin
        if (m_tvalid && m_tready) check_token();
        if (rx_hold > 0) begin
            m_tready <= 1'b0;
            rx_hold--;
        end else if (rx_gap > 0) begin
            m_tready <= 1'b0;
            rx_gap--;
        end else if (idle_on && $urandom_range(0, 6) == 0) begin
            m_tready <= 1'b0;
            rx_gap = $urandom_range(0, 11);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------- source side

    task automatic send_beat(input logic [7:0] c, input logic eot);
        int gap;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 12);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= eot;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_tokens(c, eot);
        items_sent++;
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++) send_beat(s[i], 1'b0);
    endtask

    // text_byte is don't-care on an end beat
    task automatic send_end();
        send_beat(8'($urandom_range(0, 255)), 1'b1);
    endtask

    function automatic logic [7:0] rand_alpha();
        int r;
        r = $urandom_range(0, 52);
        if (r < 26) return 8'("a" + r);
        if (r < 52) return 8'("A" + r - 26);
        return "_";
    endfunction

    function automatic logic [7:0] rand_digit();
        return 8'("0" + $urandom_range(0, 9));
    endfunction

    // mostly well-formed lexemes with random content, some noise and end beats
    task automatic send_lexeme();
        int pick, n, i, w;
        logic [7:0] c;
        string puncts, ops;
        logic [31:0] blanks;
        puncts = "(){},.-+;*";
        ops    = "!=<>";
        pick   = $urandom_range(0, 99);
        if (pick < 14) begin
            w = $urandom_range(0, KEYWORDS - 1);
            for (i = 0; i < 8; i++) begin
                c = KW_TABLE[w][8*i +: 8];
                if (c != 8'h00) send_beat(c, 1'b0);
            end
        end else if (pick < 28) begin
            n = ($urandom_range(0, 5) == 0) ? $urandom_range(7, 10) : $urandom_range(1, 6);
            send_beat(rand_alpha(), 1'b0);
            for (i = 1; i < n; i++)
                send_beat(($urandom_range(0, 3) == 0) ? rand_digit() : rand_alpha(), 1'b0);
        end else if (pick < 42) begin
            n = $urandom_range(1, 4);
            for (i = 0; i < n; i++) send_beat(rand_digit(), 1'b0);
            if ($urandom_range(0, 1) == 1) begin
                send_beat(".", 1'b0);
                n = $urandom_range(0, 3);
                for (i = 0; i < n; i++) send_beat(rand_digit(), 1'b0);
            end
        end else if (pick < 52) begin
            send_beat(CH_QUOTE, 1'b0);
            n = $urandom_range(0, 6);
            for (i = 0; i < n; i++)
                send_beat(($urandom_range(0, 6) == 0) ? CH_LF : 8'($urandom_range(32, 126)),
                          1'b0);
            // sometimes left open, so the next lexeme runs on inside the string
            if ($urandom_range(0, 9) != 0) send_beat(CH_QUOTE, 1'b0);
        end else if (pick < 66) begin
            if ($urandom_range(0, 4) == 0) begin
                send_beat("/", 1'b0);
            end else begin
                send_beat(ops[$urandom_range(0, 3)], 1'b0);
                if ($urandom_range(0, 1) == 1) send_beat("=", 1'b0);
            end
        end else if (pick < 78) begin
            send_beat(puncts[$urandom_range(0, 9)], 1'b0);
        end else if (pick < 83) begin
            send_text("//");
            n = $urandom_range(0, 8);
            for (i = 0; i < n; i++) send_beat(8'($urandom_range(0, 255)), 1'b0);
            send_beat(CH_LF, 1'b0);
        end else if (pick < 90) begin
            blanks = {CH_SPACE, CH_TAB, CH_CR, CH_LF};
            send_beat(blanks[8*$urandom_range(0, 3) +: 8], 1'b0);
        end else if (pick < 96) begin
            send_beat(8'($urandom_range(0, 255)), 1'b0);
        end else begin
            send_end();
        end
        if ($urandom_range(0, 2) == 0) send_beat(CH_SPACE, 1'b0);
    endtask

    // ---------------------------------------------------------------- tests

    // short hand-picked text: three tokens from one beat, comment, operator pair,
    // string over a newline, null and high bytes, keyword, dot flushed at end,
    // double end marker, unterminated string, input after end
    task automatic test_directed();
        send_text("1.(");
        send_text("//x\n");
        send_text("<=");
        send_text("\"a\n\"");
        send_beat(8'h00, 1'b0);
        send_beat(8'hFF, 1'b0);
        send_text("if ");
        send_text("2.");
        send_end();
        send_end();
        send_text("\"z");
        send_end();
    endtask

    task automatic test_random_text();
        int stop_at;
        stop_at = items_sent + RANDOM_ITEMS;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 24) == 0) idle_on = !idle_on;
            send_lexeme();
        end
        idle_on = 1'b1;
    endtask

    // receiver holds off while the source keeps offering beats until s_tready drops;
    // one token per punctuation beat fills the queue and the issue stage for sure
    task automatic test_output_hold();
        int i;
        rx_hold = 200;
        send_text("(){},;+-*");
        for (i = 0; i < 6; i++) send_lexeme();
    endtask

    // closing stretch with no idle cycles on either side
    task automatic test_steady_stream();
        int i;
        idle_on = 1'b0;
        for (i = 0; i < STEADY_LEXEMES; i++) send_lexeme();
        send_end();
    endtask

    initial begin
        int n;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random_text();
        test_output_hold();
        test_steady_stream();
        s_tvalid <= 1'b0;
        for (n = 0; n < 4000 && expected_tokens.size() != 0; n++) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (expected_tokens.size() != 0) begin
            err_count++;
            $display("%0t: tokens missing, expected %0d more, actual 0",
                     $time, expected_tokens.size());
        end
        if (err_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // ends the run as failed if the bench hangs
    initial begin
        #20_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
